// File: rtl/b32enc_pkg.sv
// Shared types, constants and checksum helpers for the Bech32 string encoder.
`timescale 1ns / 1ps
package b32enc_pkg;

	localparam int MAX_TOTAL = 108;
	localparam int HRP_DEPTH = 128;
	localparam int HRP_AW    = (HRP_DEPTH > 1) ? $clog2(HRP_DEPTH) : 1;

	localparam logic [29:0] GEN0 = 30'h3b6a57b2;
	localparam logic [29:0] GEN1 = 30'h26508e6d;
	localparam logic [29:0] GEN2 = 30'h1ea119fa;
	localparam logic [29:0] GEN3 = 30'h3d4233dd;
	localparam logic [29:0] GEN4 = 30'h2a1462b3;

	localparam logic [255:0] CHARSET_STR = "qpzry9x8gf2tvdw0s3jn54khce6mua7l";
	localparam logic [6:0]   SEP_CHAR    = 7'h31;

	localparam logic ACT_HRP  = 1'b0;
	localparam logic ACT_DATA = 1'b1;

	localparam logic [2:0] ERR_NONE     = 3'd0;
	localparam logic [2:0] ERR_HRP_CHAR = 3'd1;
	localparam logic [2:0] ERR_SYMBOL   = 3'd2;
	localparam logic [2:0] ERR_LENGTH   = 3'd3;
	localparam logic [2:0] ERR_ORDER    = 3'd4;

	typedef struct packed {
		logic       action;
		logic [7:0] value;
		logic       end_of_part;
	} item_t;

	typedef struct packed {
		logic [6:0] out_char;
		logic       last;
		logic [2:0] error_code;
		logic [6:0] total_length;
	} res_t;

	// One BCH polymod step with a zero symbol folded in.
	function automatic logic [29:0] poly_step(input logic [29:0] c);
		logic [29:0] r;
		begin
			r = {c[24:0], 5'b0};
			if (c[25]) r = r ^ GEN0;
			if (c[26]) r = r ^ GEN1;
			if (c[27]) r = r ^ GEN2;
			if (c[28]) r = r ^ GEN3;
			if (c[29]) r = r ^ GEN4;
			return r;
		end
	endfunction

	// First character sits in the top byte of the packed string.
	function automatic logic [6:0] charset(input logic [4:0] s);
		logic [7:0] base;
		begin
			base = {~s, 3'b000};
			return CHARSET_STR[base +: 7];
		end
	endfunction

endpackage

// File: rtl/b32enc_ram.sv
// Generic single-port-write, single-port-read RAM with registered read data.
`timescale 1ns / 1ps
module b32enc_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16,
	parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

// File: rtl/bech32_string_encoder_unit.sv
// Top level of the streaming Bech32 string encoder.
// The first result word of an item is valid in the cycle after acceptance.
// Accepts one hrp character or non-final data symbol per cycle while the output is free;
//   after the final hrp character it walks the stored low parts (one RAM read per low part)
//   and emits the separator; after the final symbol, six zero steps and six checksum words.
// Reset: arst_n clears control state and counters and sets the checksum to one; the RAM is not cleared.
`timescale 1ns / 1ps
module bech32_string_encoder_unit (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                item_valid,
	output logic                item_stall,
	input  b32enc_pkg::item_t   item,
	output logic                res_valid,
	input  logic                res_stall,
	output b32enc_pkg::res_t    res
);
	import b32enc_pkg::*;

	typedef enum logic [2:0] {
		S_IDLE,
		S_WALK,
		S_SEP,
		S_FIN,
		S_CHK
	} state_t;

	state_t          state_q;
	logic [29:0]     chk_q;
	logic [6:0]      hrp_q;
	logic [6:0]      char_q;
	logic            phase_q;      // 0: expect hrp, 1: expect data
	logic [6:0]      walk_idx_q;
	logic            rd_pend_s1;
	logic [2:0]      step_q;
	logic            res_valid_q;
	res_t            res_q;

	logic            can_emit;
	logic            acc;
	logic [2:0]      err;
	logic [29:0]     chk_hrp;
	logic [29:0]     chk_data;
	logic            walk_issue;
	logic            ram_we;
	logic [4:0]      ram_rdata;
	logic [6:0]      char_inc;

	// The output register frees up when empty or when its word is taken this cycle.
	assign can_emit   = !res_valid_q || !res_stall;
	assign item_stall = !(state_q == S_IDLE && can_emit);
	assign acc        = item_valid && !item_stall;
	assign res_valid  = res_valid_q;
	assign res        = res_q;
	assign char_inc   = char_q + 7'd1;

	// Check order first, then length, then the value itself.
	always_comb begin
		err = ERR_NONE;
		if (item.action == ACT_HRP) begin
			if (phase_q) begin
				err = ERR_ORDER;
			end else if (({1'b0, hrp_q} + 8'd9 > 8'(MAX_TOTAL)) ||
					({1'b0, hrp_q} >= 8'(HRP_DEPTH))) begin
				err = ERR_LENGTH;
			end else if (item.value < 8'd33 || item.value > 8'd126) begin
				err = ERR_HRP_CHAR;
			end
		end else begin
			if (!phase_q) begin
				err = ERR_ORDER;
			end else if ({1'b0, char_q} + 8'd7 > 8'(MAX_TOTAL)) begin
				err = ERR_LENGTH;
			end else if (item.value >= 8'd32) begin
				err = ERR_SYMBOL;
			end
		end
	end

	assign chk_hrp  = poly_step(chk_q) ^ {27'b0, item.value[7:5]};
	assign chk_data = poly_step(chk_q) ^ {25'b0, item.value[4:0]};

	// Store the hrp low part at the current hrp position. The walk reads it no earlier
	// than the next cycle, so write and read never overlap on one entry.
	assign ram_we     = acc && item.action == ACT_HRP && err == ERR_NONE;
	assign walk_issue = (state_q == S_WALK) && (walk_idx_q != hrp_q);

	b32enc_ram #(
		.WIDTH (5),
		.DEPTH (HRP_DEPTH)
	) u_hrp_ram (
		.clk   (clk),
		.we    (ram_we),
		.waddr (hrp_q[HRP_AW-1:0]),
		.wdata (item.value[4:0]),
		.raddr (walk_idx_q[HRP_AW-1:0]),
		.rdata (ram_rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			chk_q       <= 30'd1;
			hrp_q       <= '0;
			char_q      <= '0;
			phase_q     <= 1'b0;
			walk_idx_q  <= '0;
			rd_pend_s1  <= 1'b0;
			step_q      <= '0;
			res_valid_q <= 1'b0;
			res_q       <= '0;
		end else begin
			// Drop the output word once taken; an emit below overrides this.
			if (!res_stall) begin
				res_valid_q <= 1'b0;
			end
			unique case (state_q)
				S_IDLE: begin
					if (acc) begin
						res_valid_q <= 1'b1;
						if (err != ERR_NONE) begin
							// Abort the string: one error word, then fresh state.
							res_q   <= '{out_char: 7'd0, last: 1'b1, error_code: err,
								total_length: char_q};
							chk_q   <= 30'd1;
							hrp_q   <= '0;
							char_q  <= '0;
							phase_q <= 1'b0;
						end else if (item.action == ACT_HRP) begin
							res_q  <= '{out_char: item.value[6:0], last: 1'b0,
								error_code: ERR_NONE, total_length: char_inc};
							hrp_q  <= hrp_q + 7'd1;
							char_q <= char_inc;
							if (item.end_of_part) begin
								// Fold the zero step now, then walk the stored low parts.
								chk_q      <= poly_step(chk_hrp);
								walk_idx_q <= '0;
								rd_pend_s1 <= 1'b0;
								state_q    <= S_WALK;
							end else begin
								chk_q <= chk_hrp;
							end
						end else begin
							res_q  <= '{out_char: charset(item.value[4:0]), last: 1'b0,
								error_code: ERR_NONE, total_length: char_inc};
							char_q <= char_inc;
							chk_q  <= chk_data;
							if (item.end_of_part) begin
								step_q  <= '0;
								state_q <= S_FIN;
							end
						end
					end
				end
				S_WALK: begin
					// Issue one read a cycle and fold the word read the cycle before.
					if (walk_issue) begin
						walk_idx_q <= walk_idx_q + 7'd1;
					end
					rd_pend_s1 <= walk_issue;
					if (rd_pend_s1) begin
						chk_q <= poly_step(chk_q) ^ {25'b0, ram_rdata};
					end
					if (!walk_issue && !rd_pend_s1) begin
						state_q <= S_SEP;
					end
				end
				S_SEP: begin
					if (can_emit) begin
						res_valid_q <= 1'b1;
						res_q   <= '{out_char: SEP_CHAR, last: 1'b0, error_code: ERR_NONE,
							total_length: char_inc};
						char_q  <= char_inc;
						phase_q <= 1'b1;
						state_q <= S_IDLE;
					end
				end
				S_FIN: begin
					// Six zero steps; the last one also applies the final xor with one.
					chk_q <= poly_step(chk_q) ^ {29'b0, (step_q == 3'd5)};
					if (step_q == 3'd5) begin
						step_q  <= '0;
						state_q <= S_CHK;
					end else begin
						step_q <= step_q + 3'd1;
					end
				end
				S_CHK: begin
					if (can_emit) begin
						res_valid_q <= 1'b1;
						res_q  <= '{out_char: charset(chk_q[29:25]), last: (step_q == 3'd5),
							error_code: ERR_NONE, total_length: char_inc};
						if (step_q == 3'd5) begin
							chk_q   <= 30'd1;
							hrp_q   <= '0;
							char_q  <= '0;
							phase_q <= 1'b0;
							step_q  <= '0;
							state_q <= S_IDLE;
						end else begin
							chk_q  <= {chk_q[24:0], 5'b0};
							char_q <= char_inc;
							step_q <= step_q + 3'd1;
						end
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

endmodule

// File: rtl/b32enc_chk.sv
// Port-level checker for the Bech32 string encoder, bound to the top level.
`timescale 1ns / 1ps
module b32enc_chk (
	input logic              clk,
	input logic              arst_n,
	input logic              item_valid,
	input logic              item_stall,
	input logic              res_valid,
	input logic              res_stall,
	input b32enc_pkg::res_t  res
);
	import b32enc_pkg::*;

	// A stalled result word holds.
	a_res_hold: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && res_stall |=> res_valid && $stable(res))
		else $error("result word changed under stall");

	// Every accepted input word puts a result word out on the next cycle.
	a_in_answer: assert property (@(posedge clk) disable iff (!arst_n)
		item_valid && !item_stall |=> res_valid)
		else $error("accepted word produced no result word");

	// An error word ends the string and carries no character.
	a_err_word: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && res.error_code != ERR_NONE |-> res.last && res.out_char == 7'd0)
		else $error("error word not marked last or carries a character");

	// A completed string holds at least one hrp char, separator, one symbol, checksum.
	a_min_len: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && res.last && res.error_code == ERR_NONE |->
			res.total_length >= 7'd9)
		else $error("completed string too short");

	// Never emit past the length limit.
	a_max_len: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid |-> {1'b0, res.total_length} <= 8'(MAX_TOTAL))
		else $error("string length beyond limit");

endmodule

bind bech32_string_encoder_unit b32enc_chk u_b32enc_chk (
	.clk        (clk),
	.arst_n     (arst_n),
	.item_valid (item_valid),
	.item_stall (item_stall),
	.res_valid  (res_valid),
	.res_stall  (res_stall),
	.res        (res)
);

// File: dv/tb.sv
// Self-checking testbench for the streaming Bech32 string encoder.
`timescale 1ns / 1ps
module tb;
	import b32enc_pkg::*;

	// Quiet cycles without any handshake before the run is declared hung. The slowest
	// word (the closing hrp character) walks up to about a hundred stored low parts.
	localparam int HANG_LIMIT = 3000;
	// Cycles to wait after the last expected word, longer than the slowest word.
	localparam int DRAIN_CYCLES = 150;
	localparam int WORD_TARGET = 420;

	typedef enum logic {AWAIT_HRP, AWAIT_DATA} part_t;

	// Tracks the string being encoded and holds the words the encoder owes us.
	class encoded_string_model;
		res_t        pending_chars[$];
		logic [29:0] chk;
		logic [4:0]  hrp_low[128];
		int unsigned hrp_len;
		int unsigned emitted;
		part_t       part;
		int          failures;
		int          words_out;
		int          completed;
		int          err_hits[5];
		string       alphabet;

		function new();
			alphabet = "qpzry9x8gf2tvdw0s3jn54khce6mua7l";
			failures = 0;
			words_out = 0;
			completed = 0;
			foreach (err_hits[k]) err_hits[k] = 0;
			restart();
		endfunction

		function void restart();
			chk = 30'd1;
			hrp_len = 0;
			emitted = 0;
			part = AWAIT_HRP;
		endfunction

		// Shift one 5-bit symbol into the BCH remainder.
		function logic [29:0] fold(logic [29:0] c, logic [4:0] sym);
			logic [29:0] gens[5];
			logic [29:0] r;
			gens = '{GEN0, GEN1, GEN2, GEN3, GEN4};
			r = {c[24:0], 5'd0} ^ {25'd0, sym};
			for (int k = 0; k < 5; k++)
				if (c[25 + k]) r = r ^ gens[k];
			return r;
		endfunction

		function logic [6:0] to_char(logic [4:0] s);
			byte b;
			b = alphabet.getc(s);
			return b[6:0];
		endfunction

		function void expect_char(logic [6:0] ch, logic lst, logic [2:0] code);
			res_t r;
			r.out_char = ch;
			r.last = lst;
			r.error_code = code;
			r.total_length = emitted[6:0];
			pending_chars.push_back(r);
		endfunction

		function void reject(logic [2:0] code);
			expect_char(7'd0, 1'b1, code);
			err_hits[code]++;
			restart();
		endfunction

		function void complain(string msg);
			failures++;
			if (failures <= 10) $display("MISMATCH at %0t: %s", $realtime, msg);
		endfunction

		// Note one accepted input word and queue what it must produce.
		function void take_word(item_t w);
			logic [29:0] c;
			if (w.action == ACT_HRP) begin
				if (part != AWAIT_HRP) reject(ERR_ORDER);
				else if (hrp_len + 9 > MAX_TOTAL || hrp_len >= HRP_DEPTH) reject(ERR_LENGTH);
				else if (w.value < 8'd33 || w.value > 8'd126) reject(ERR_HRP_CHAR);
				else begin
					chk = fold(chk, {2'b00, w.value[7:5]});
					hrp_low[hrp_len] = w.value[4:0];
					hrp_len++;
					emitted++;
					expect_char(w.value[6:0], 1'b0, ERR_NONE);
					if (w.end_of_part) begin
						// Separator: a zero step, then the low parts in order.
						chk = fold(chk, 5'd0);
						for (int i = 0; i < hrp_len; i++) chk = fold(chk, hrp_low[i]);
						emitted++;
						expect_char(SEP_CHAR, 1'b0, ERR_NONE);
						part = AWAIT_DATA;
					end
				end
			end else begin
				if (part != AWAIT_DATA) reject(ERR_ORDER);
				else if (emitted + 7 > MAX_TOTAL) reject(ERR_LENGTH);
				else if (w.value > 8'd31) reject(ERR_SYMBOL);
				else begin
					chk = fold(chk, w.value[4:0]);
					emitted++;
					expect_char(to_char(w.value[4:0]), 1'b0, ERR_NONE);
					if (w.end_of_part) begin
						c = chk;
						for (int i = 0; i < 6; i++) c = fold(c, 5'd0);
						c = c ^ 30'd1;
						for (int i = 0; i < 6; i++) begin
							emitted++;
							expect_char(to_char(c[(5 - i) * 5 +: 5]), i == 5, ERR_NONE);
						end
						completed++;
						restart();
					end
				end
			end
		endfunction

		// Compare one accepted result word with the oldest one owed.
		function void match_char(res_t got);
			res_t want;
			words_out++;
			if (pending_chars.size() == 0) begin
				complain($sformatf("unexpected word char %h last %b err %0d len %0d",
					got.out_char, got.last, got.error_code, got.total_length));
				return;
			end
			want = pending_chars.pop_front();
			if (got !== want)
				complain($sformatf({"char %h/%h last %b/%b err %0d/%0d len %0d/%0d",
					" (expected/actual)"},
					want.out_char, got.out_char, want.last, got.last,
					want.error_code, got.error_code, want.total_length, got.total_length));
		endfunction
	endclass

	logic  clk = 1'b0;
	logic  arst_n = 1'b0;
	logic  item_valid = 1'b0;
	logic  item_stall;
	item_t item = '0;
	logic  res_valid;
	logic  res_stall = 1'b0;
	res_t  res;

	encoded_string_model model = new();
	int src_idle_pct = 34;
	int sink_idle_pct = 52;
	int words_in = 0;

	bech32_string_encoder_unit uut (
		.clk        (clk),
		.arst_n     (arst_n),
		.item_valid (item_valid),
		.item_stall (item_stall),
		.item       (item),
		.res_valid  (res_valid),
		.res_stall  (res_stall),
		.res        (res)
	);

	initial begin
		forever #5 clk = ~clk;
	end

	// Result side: check every word taken at this edge, then pick the next stall.
	// Outputs are sampled before the edge updates them, so there is no race.
	always @(posedge clk) begin
		if (arst_n && res_valid && !res_stall) model.match_char(res);
		res_stall <= ($urandom_range(99) < sink_idle_pct);
	end

	// Hang detector: restart the count on any handshake, on either side.
	initial begin : hang_watch
		int quiet;
		quiet = 0;
		while (quiet < HANG_LIMIT) begin
			@(posedge clk);
			if ((item_valid && !item_stall) || (res_valid && !res_stall)) quiet = 0;
			else quiet++;
		end
		$display("Timeout: no handshake for %0d cycles", HANG_LIMIT);
		$display("Verification failed");
		$finish;
	end

	// Present one input word and hold it until the encoder takes it.
	// Valid stays high across back-to-back words; drop it only to idle.
	task automatic send_word(input logic act, input logic [7:0] v, input logic eop);
		item_t w;
		w.action = act;
		w.value = v;
		w.end_of_part = eop;
		// Idle schedule: receiver-heavy gaps, then sender-heavy, then full speed.
		if (words_in < 150) begin
			src_idle_pct = 34;
			sink_idle_pct = 52;
		end else if (words_in < 300) begin
			src_idle_pct = 52;
			sink_idle_pct = 34;
		end else begin
			src_idle_pct = 0;
			sink_idle_pct = 0;
		end
		while ($urandom_range(99) < src_idle_pct) begin
			item_valid <= 1'b0;
			@(posedge clk);
		end
		item_valid <= 1'b1;
		item <= w;
		@(posedge clk);
		while (item_stall) @(posedge clk);
		model.take_word(w);
		words_in++;
	endtask

	// Send one string of random legal content; noise corrupts a fraction of words
	// by a wild value, a swapped action or a misplaced end marker.
	task automatic send_string(input int hlen, input int dlen, input int noise_pct);
		logic       act;
		logic [7:0] v;
		logic       eop;
		for (int i = 0; i < hlen + dlen; i++) begin
			act = (i < hlen) ? ACT_HRP : ACT_DATA;
			v = (i < hlen) ? 8'($urandom_range(33, 126)) : 8'($urandom_range(0, 31));
			eop = (i == hlen - 1) || (i == hlen + dlen - 1);
			if ($urandom_range(99) < noise_pct) begin
				case ($urandom_range(2))
					0: begin
						v = 8'($urandom_range(255));
					end
					1: begin
						act = ~act;
					end
					default: begin
						eop = ~eop;
					end
				endcase
			end
			send_word(act, v, eop);
		end
	endtask

	initial begin : stimulus
		int hlen;
		int dlen;
		int n;

		// Hold reset, then release it on an edge.
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed words.
		send_word(ACT_DATA, 8'd0, 1'b1);     // data with an empty hrp
		send_word(ACT_HRP, 8'd33, 1'b0);     // lowest legal hrp character
		send_word(ACT_HRP, 8'd126, 1'b1);    // highest legal hrp character
		send_word(ACT_DATA, 8'd0, 1'b0);
		send_word(ACT_DATA, 8'd31, 1'b0);
		send_word(ACT_DATA, 8'd5, 1'b1);     // closes the string with a checksum
		send_word(ACT_HRP, 8'd32, 1'b0);     // just below the legal range
		send_word(ACT_HRP, 8'd127, 1'b0);    // just above it
		send_word(ACT_HRP, 8'd0, 1'b1);
		send_word(ACT_HRP, 8'd255, 1'b1);
		send_word(ACT_HRP, 8'd97, 1'b1);
		send_word(ACT_DATA, 8'd32, 1'b0);    // first illegal symbol
		send_word(ACT_HRP, 8'd98, 1'b1);
		send_word(ACT_DATA, 8'd255, 1'b1);
		send_word(ACT_HRP, 8'd99, 1'b1);
		send_word(ACT_HRP, 8'd100, 1'b0);    // hrp character after the separator
		send_word(ACT_HRP, 8'd120, 1'b0);
		send_word(ACT_DATA, 8'd3, 1'b1);     // data before the hrp was closed

		// Random strings; a few long ones probe the length limit.
		n = 0;
		while (words_in < WORD_TARGET) begin
			if (n == 1) begin
				// The hundred-and-first hrp character overflows.
				hlen = 101;
				dlen = 1;
			end else if (n == 4) begin
				// The last data symbol overflows.
				hlen = $urandom_range(1, 3);
				dlen = 102 - hlen;
			end else if (n == 8) begin
				// Fill the string to exactly the maximum length.
				hlen = $urandom_range(40, 60);
				dlen = 101 - hlen;
			end else begin
				hlen = $urandom_range(0, 8);
				dlen = $urandom_range(1, 20);
			end
			send_string(hlen, dlen, (n == 1 || n == 4 || n == 8) ? 0 : 8);
			n++;
		end
		item_valid <= 1'b0;

		// Drain everything owed, then watch a while for strays.
		while (model.pending_chars.size() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (model.pending_chars.size() != 0)
			model.complain($sformatf("%0d words never arrived", model.pending_chars.size()));

		$display("Run covered %0d input words: 18 directed, %0d random strings (%0d %s",
			words_in, n, model.completed, "closed with a checksum in all),");
		$display("  %0d result words; errors seen: bad hrp %0d, bad symbol %0d, %s %0d, %s %0d.",
			model.words_out, model.err_hits[ERR_HRP_CHAR], model.err_hits[ERR_SYMBOL],
			"too long", model.err_hits[ERR_LENGTH],
			"out of order", model.err_hits[ERR_ORDER]);
		if (model.failures == 0) begin
			$display("Verification passed");
		end else begin
			$display("Verification failed");
		end
		$finish;
	end

endmodule
